FILE: hdl/hiae_pkg.sv
// Shared types, constants and helpers of the HFI angle estimator.
`default_nettype none

package hiae_pkg;

   // Quarter-wave sine polynomial coefficients (Q15 arithmetic)
   localparam logic [15:0] POLY_A = 16'd51472;
   localparam logic [15:0] POLY_B = 16'd21023;
   localparam logic [15:0] POLY_C = 16'd2320;

   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [14:0] SINE_MAX     = 15'h7FFF;

   // Divider pass length
   localparam logic [5:0] DIV_STEPS_ERR = 6'd32;

   // Register indexes
   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_PHASE_STEP = 2'd1;
   localparam logic [1:0] REG_AMPLITUDE  = 2'd2;
   localparam logic [1:0] REG_COS_AXIS   = 2'd3;

   // Item kind carried on req_tuser
   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_ANALYZE = 1'b1
   } func_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TICK_LOAD,
      ST_IDX_MUL,
      ST_IDX_TAKE,
      ST_CIDX_START,
      ST_SIN0,
      ST_SIN1,
      ST_SIN2,
      ST_SIN3,
      ST_SIN4,
      ST_SCALE_MUL,
      ST_SCALE_TAKE,
      ST_PARK0,
      ST_PARK1,
      ST_PARK2,
      ST_PARK3,
      ST_PARK4,
      ST_ERR_START,
      ST_ERR_WAIT,
      ST_DONE
   } state_type;

   // Which value the sine pass is producing
   typedef enum logic [1:0] {
      SEL_TICK_S,
      SEL_TICK_C,
      SEL_TAB_S,
      SEL_TAB_C
   } sine_sel_type;

   typedef struct packed {
      logic        start;
      logic [15:0] rem_init;
      logic [31:0] dividend;
      logic [15:0] divisor;
      logic [5:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   // floor shift right by 15, saturate to signed 16
   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      logic signed [17:0] sh;
      sh = v[32:15];
      if (sh > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (sh < -18'sd32768) begin
         return 16'sh8000;
      end else begin
         return sh[15:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/hiae_mul.sv
// Shared signed 18x18 multiplier with registered product.
`default_nettype none

module hiae_mul (
   input  logic               clock,
   input  logic signed [17:0] op_a,
   input  logic signed [17:0] op_b,
   output logic signed [35:0] product
);

   logic signed [35:0] product_ff;
   logic signed [35:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

FILE: hdl/hiae_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module hiae_div import hiae_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        run_ff;
   logic [5:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [31:0] dvd_ff;
   logic [15:0] dsr_ff;
   logic [31:0] quo_ff;

   logic [16:0] trial;
   logic        ge;
   logic [16:0] diff;
   logic [15:0] rem_in;

   assign trial  = {rem_ff, dvd_ff[31]};
   assign ge     = (trial >= {1'b0, dsr_ff});
   assign diff   = trial - {1'b0, dsr_ff};
   assign rem_in = ge ? diff[15:0] : trial[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else if (req.start) begin
         run_ff <= 1'b1;
         cnt_ff <= req.steps;
      end else if (run_ff) begin
         if (cnt_ff != 6'd0) begin
            cnt_ff <= cnt_ff - 6'd1;
         end else begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         dvd_ff <= req.dividend;
         dsr_ff <= req.divisor;
         quo_ff <= 32'd0;
      end else if (run_ff && cnt_ff != 6'd0) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   assign rsp.done     = run_ff && (cnt_ff == 6'd0);
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/hfi_injection_angle_estimator_core.sv
// Top level of the HFI injection generator and angle-error estimator.
`default_nettype none

// HFI injection / angle-error estimator. Each req item is an injection tick
// (tuser = 0) or a current sample to analyze (tuser = 1); every item gives
// exactly one rsp item. A tick advances the phase accumulator by phase_step
// and returns amplitude*sin(phase) on inject_a and, with the cosine axis on,
// amplitude*cos(phase) on inject_b. A sample is Park-rotated by rotor_angle,
// stored as the d/q pair of the positive or negative injection half cycle,
// and the angle error (d_pos-d_neg)/(q_pos-q_neg) in Q16.16 is updated
// (held when the q difference is zero). With enable clear every item returns
// zero injection and the held error, and no state changes.
// Timing: one item at a time; req_tready is high only while idle. All math
// runs on one 18x18 multiplier and one bit-serial divider. A tick runs the
// sine pass a second time with the cosine axis on; a sample's error division
// is skipped when the q difference is zero; a disabled item goes straight to
// its result. The rsp output is registered, so a new item is taken while
// the previous result still waits for rsp_tready; a finished item stalls in
// its last state only while that register is still full. SINE_TABLE_ENTRIES
// must be a power of two: a table entry's phase is its index shifted up.
// Config must be written while idle.

module hfi_injection_angle_estimator_core import hiae_pkg::*; #(
   parameter int PHASE_BITS         = 16,
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // req stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // current_a[15:0], current_b[31:16], rotor_angle[47:32]
   input  logic        req_tuser,   // func: 0 tick, 1 analyze
   // rsp stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // inject_a[15:0], inject_b[31:16], angle_error[63:32]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = $clog2(SINE_TABLE_ENTRIES);
   localparam int SW = (PHASE_BITS > 16) ? PHASE_BITS : 16;
   localparam int QTR = SINE_TABLE_ENTRIES / 4;
   localparam int TAB_SHIFT = 16 - IW;
   localparam logic signed [17:0] ENTRIES_OP = 18'(SINE_TABLE_ENTRIES);
   localparam logic [IW:0] ENTRIES_X = (IW + 1)'(SINE_TABLE_ENTRIES);
   localparam logic [IW:0] QTR_X = (IW + 1)'(QTR);

   // ---------------- configuration registers ----------------
   logic        en_ff;
   logic [15:0] step_ff;
   logic [14:0] amp_ff;
   logic        dual_ff;
   logic        csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b0;
         step_ff <= 16'd0;
         amp_ff  <= 15'd0;
         dual_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ENABLE:     en_ff   <= csr_pwdata[0];
            REG_PHASE_STEP: step_ff <= csr_pwdata[15:0];
            REG_AMPLITUDE:  amp_ff  <= csr_pwdata[14:0];
            REG_COS_AXIS:   dual_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ENABLE:     csr_prdata = {31'd0, en_ff};
         REG_PHASE_STEP: csr_prdata = {16'd0, step_ff};
         REG_AMPLITUDE:  csr_prdata = {17'd0, amp_ff};
         REG_COS_AXIS:   csr_prdata = {31'd0, dual_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------- state ----------------
   state_type    state_ff, state_in;
   sine_sel_type sel_ff;

   logic [PHASE_BITS-1:0] acc_ff;      // injection phase accumulator
   logic signed [15:0]    dpos_ff, qpos_ff, dneg_ff, qneg_ff;
   logic signed [31:0]    err_ff;      // held angle error

   // working registers
   logic signed [15:0] a_ff, b_ff;
   logic [15:0]        rot_ff;
   logic [15:0]        p_ff;           // phase fed to the sine pass
   logic [15:0]        x_ff, y_ff;     // folded phase and its square
   logic [14:0]        mag_ff;
   logic               neg_ff;
   logic signed [15:0] s_ff, c_ff;     // table sine / cosine at rotor angle
   logic signed [32:0] sum_ff;
   logic signed [15:0] d_ff;
   logic signed [15:0] ia_ff, ib_ff;
   logic [IW-1:0]      cidx_ff;
   logic               eneg_ff;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;

   // ---------------- shared units ----------------
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_q;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   hiae_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_q)
   );

   hiae_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------- combinational helpers ----------------
   logic                  accept;
   logic [SW-1:0]         acc_sum;
   logic [PHASE_BITS+15:0] acc_shift;
   logic [15:0]           ph16;
   logic                  pos_half;

   assign accept    = req_tvalid && req_tready;
   assign acc_sum   = SW'(acc_ff) + SW'(step_ff);
   // top 16 bits of the accumulator, left-aligned when it is narrower
   assign acc_shift = {acc_ff, 16'h0000};
   assign ph16      = acc_shift[PHASE_BITS+15:PHASE_BITS];
   // sine strictly positive: first half turn, not at the zero crossing
   assign pos_half  = !ph16[15] && (ph16[14:0] != 15'd0);

   // quadrant fold: x in Q15, 0..32768
   logic [15:0] xr_c, x_c;
   assign xr_c = {1'b0, p_ff[13:0], 1'b0};
   assign x_c  = p_ff[14] ? (16'h8000 - xr_c) : xr_c;

   // polynomial steps, all products are non-negative and below 2^31
   logic [15:0]        y_c, t2_c, t3_c, raw_c;
   logic [14:0]        mag_c;
   logic signed [15:0] sv_c;
   assign y_c   = mul_q[30:15];
   assign t2_c  = POLY_B - mul_q[30:15];
   assign t3_c  = POLY_A - mul_q[30:15];
   assign raw_c = mul_q[30:15];
   assign mag_c = raw_c[15] ? SINE_MAX : raw_c[14:0];
   assign sv_c  = p_ff[15] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

   // amplitude scaling, truncated toward zero
   logic [14:0]        scl_c;
   logic signed [15:0] scl_val;
   assign scl_c   = mul_q[29:15];
   assign scl_val = neg_ff ? -$signed({1'b0, scl_c}) : $signed({1'b0, scl_c});

   // table index and its quarter-turn partner
   logic [IW-1:0] idx_c;
   logic [IW:0]   csum_c;
   logic [IW-1:0] cidx_c;
   assign idx_c  = mul_q[IW+15:16];
   assign csum_c = {1'b0, idx_c} + QTR_X;
   assign cidx_c = (csum_c >= ENTRIES_X) ? IW'(csum_c - ENTRIES_X) : csum_c[IW-1:0];

   // Park sums
   logic signed [15:0] park_d_c, park_q_c;
   assign park_d_c = sat16(sum_ff + mul_q[32:0]);
   assign park_q_c = sat16(sum_ff - mul_q[32:0]);

   // error operands
   logic signed [16:0] dd_c, qd_c, add_c, aqd_c;
   assign dd_c  = {dpos_ff[15], dpos_ff} - {dneg_ff[15], dneg_ff};
   assign qd_c  = {qpos_ff[15], qpos_ff} - {qneg_ff[15], qneg_ff};
   assign add_c = dd_c[16] ? -dd_c : dd_c;
   assign aqd_c = qd_c[16] ? -qd_c : qd_c;

   // saturated signed Q16.16 from magnitude quotient
   logic [31:0] quo;
   logic [31:0] err_c;
   assign quo = div_rsp.quotient;
   always_comb begin
      if (eneg_ff) begin
         err_c = quo[31] ? 32'h8000_0000 : (32'd0 - quo);
      end else begin
         err_c = quo[31] ? 32'h7FFF_FFFF : quo;
      end
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!en_ff) begin
                  state_in = ST_DONE;
               end else if (req_tuser == FUNC_TICK) begin
                  state_in = ST_TICK_LOAD;
               end else begin
                  state_in = ST_IDX_MUL;
               end
            end
         end
         ST_TICK_LOAD:  state_in = ST_SIN0;
         ST_IDX_MUL:    state_in = ST_IDX_TAKE;
         ST_IDX_TAKE:   state_in = ST_SIN0;
         ST_CIDX_START: state_in = ST_SIN0;
         ST_SIN0:       state_in = ST_SIN1;
         ST_SIN1:       state_in = ST_SIN2;
         ST_SIN2:       state_in = ST_SIN3;
         ST_SIN3:       state_in = ST_SIN4;
         ST_SIN4: begin
            case (sel_ff)
               SEL_TAB_S: state_in = ST_CIDX_START;
               SEL_TAB_C: state_in = ST_PARK0;
               default:   state_in = ST_SCALE_MUL;
            endcase
         end
         ST_SCALE_MUL:  state_in = ST_SCALE_TAKE;
         ST_SCALE_TAKE: begin
            if (sel_ff == SEL_TICK_S && dual_ff) begin
               state_in = ST_SIN0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PARK0:      state_in = ST_PARK1;
         ST_PARK1:      state_in = ST_PARK2;
         ST_PARK2:      state_in = ST_PARK3;
         ST_PARK3:      state_in = ST_PARK4;
         ST_PARK4:      state_in = ST_ERR_START;
         ST_ERR_START:  state_in = (qd_c == 17'sd0) ? ST_DONE : ST_ERR_WAIT;
         ST_ERR_WAIT:   if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:       if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: unit controls ----------------
   always_comb begin
      req_tready = 1'b0;
      mul_a      = 18'sd0;
      mul_b      = 18'sd0;
      div_req    = '0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_IDX_MUL: begin
            mul_a = {2'b00, rot_ff};
            mul_b = ENTRIES_OP;
         end
         ST_SIN0: begin
            mul_a = {2'b00, x_c};
            mul_b = {2'b00, x_c};
         end
         ST_SIN1: begin
            mul_a = {2'b00, y_c};
            mul_b = {2'b00, POLY_C};
         end
         ST_SIN2: begin
            mul_a = {2'b00, t2_c};
            mul_b = {2'b00, y_ff};
         end
         ST_SIN3: begin
            mul_a = {2'b00, t3_c};
            mul_b = {2'b00, x_ff};
         end
         ST_SCALE_MUL: begin
            mul_a = {3'b000, mag_ff};
            mul_b = {3'b000, amp_ff};
         end
         ST_PARK0: begin
            mul_a = {{2{a_ff[15]}}, a_ff};
            mul_b = {{2{c_ff[15]}}, c_ff};
         end
         ST_PARK1: begin
            mul_a = {{2{b_ff[15]}}, b_ff};
            mul_b = {{2{s_ff[15]}}, s_ff};
         end
         ST_PARK2: begin
            mul_a = {{2{b_ff[15]}}, b_ff};
            mul_b = {{2{c_ff[15]}}, c_ff};
         end
         ST_PARK3: begin
            mul_a = {{2{a_ff[15]}}, a_ff};
            mul_b = {{2{s_ff[15]}}, s_ff};
         end
         ST_ERR_START: begin
            if (qd_c != 17'sd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {add_c[15:0], 16'h0000};
               div_req.divisor  = aqd_c[15:0];
               div_req.steps    = DIV_STEPS_ERR;
            end
         end
         default: ;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         dpos_ff      <= 16'sd0;
         qpos_ff      <= 16'sd0;
         dneg_ff      <= 16'sd0;
         qneg_ff      <= 16'sd0;
         err_ff       <= 32'sd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && accept && en_ff && req_tuser == FUNC_TICK) begin
            acc_ff <= acc_sum[PHASE_BITS-1:0];
         end
         if (state_ff == ST_PARK4) begin
            if (pos_half) begin
               dpos_ff <= d_ff;
               qpos_ff <= park_q_c;
            end else begin
               dneg_ff <= d_ff;
               qneg_ff <= park_q_c;
            end
         end
         if (state_ff == ST_ERR_WAIT && div_rsp.done) begin
            err_ff <= $signed(err_c);
         end
      end
   end

   // ---------------- working registers ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            a_ff   <= $signed(req_tdata[15:0]);
            b_ff   <= $signed(req_tdata[31:16]);
            rot_ff <= req_tdata[47:32];
            ia_ff  <= 16'sd0;
            ib_ff  <= 16'sd0;
         end
         ST_TICK_LOAD: begin
            p_ff   <= ph16;
            sel_ff <= SEL_TICK_S;
         end
         // table entry phase is its index scaled up to a 16-bit turn
         ST_IDX_TAKE: begin
            cidx_ff <= cidx_c;
            p_ff    <= 16'(idx_c) << TAB_SHIFT;
            sel_ff  <= SEL_TAB_S;
         end
         ST_CIDX_START: begin
            p_ff   <= 16'(cidx_ff) << TAB_SHIFT;
            sel_ff <= SEL_TAB_C;
         end
         ST_SIN0: x_ff <= x_c;
         ST_SIN1: y_ff <= y_c;
         ST_SIN4: begin
            mag_ff <= mag_c;
            neg_ff <= p_ff[15];
            if (sel_ff == SEL_TAB_S) s_ff <= sv_c;
            if (sel_ff == SEL_TAB_C) c_ff <= sv_c;
         end
         ST_SCALE_TAKE: begin
            if (sel_ff == SEL_TICK_S) begin
               ia_ff  <= scl_val;
               // cosine is the sine a quarter turn later
               p_ff   <= p_ff + QUARTER_TURN;
               sel_ff <= SEL_TICK_C;
            end else begin
               ib_ff <= scl_val;
            end
         end
         ST_PARK1: sum_ff <= mul_q[32:0];
         ST_PARK2: d_ff   <= park_d_c;
         ST_PARK3: sum_ff <= mul_q[32:0];
         ST_ERR_START: eneg_ff <= dd_c[16] ^ qd_c[16];
         ST_DONE: begin
            if (rsp_free) rsp_data_ff <= {err_ff, ib_ff, ia_ff};
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
